// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define POI_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define POI_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== design/poi_pkg.sv =====
// ----------------------------------------------------------------------------
// poi_pkg
// Types, codes and constants of the planar odometry integrator.
// ----------------------------------------------------------------------------
package poi_pkg;

   localparam int POI_TRIG_ITER_DEF = 16;
   localparam int POI_ATAN_DEPTH    = 24;
   localparam int POI_CNT_W         = 5;
   localparam int POI_FIFO_DEPTH    = 2;
   localparam int POI_CW            = 34;   // CORDIC datapath width

   localparam logic signed [POI_CW-1:0] POI_CORDIC_K = 34'sd652032874;
   localparam logic [26:0] POI_AGE_MAX = 27'h7FFFFFF;

   localparam logic signed [POI_CW-1:0] POI_ATAN_TAB [POI_ATAN_DEPTH] = '{
      34'sh020000000, 34'sh012E4051E, 34'sh009FB385B, 34'sh0051111D4,
      34'sh0028B0D43, 34'sh00145D7E1, 34'sh000A2F61E, 34'sh000517C55,
      34'sh00028BE53, 34'sh000145F2F, 34'sh0000A2F98, 34'sh0000517CC,
      34'sh000028BE6, 34'sh0000145F3, 34'sh00000A2FA, 34'sh00000517D,
      34'sh0000028BE, 34'sh00000145F, 34'sh000000A30, 34'sh000000518,
      34'sh00000028C, 34'sh000000146, 34'sh0000000A3, 34'sh000000051
   };

   typedef enum logic [1:0] {
      CMD_LATCH   = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   localparam logic [1:0] CSR_STALE_LIMIT   = 2'd0;
   localparam logic [1:0] CSR_START_X       = 2'd1;
   localparam logic [1:0] CSR_START_Y       = 2'd2;
   localparam logic [1:0] CSR_START_HEADING = 2'd3;

   typedef enum logic {
      JOB_TICK    = 1'b0,
      JOB_RESTART = 1'b1
   } job_kind_type;

   typedef struct packed {
      job_kind_type       kind;
      logic signed [23:0] vel_x;
      logic signed [23:0] vel_y;
      logic signed [31:0] turn_rate;
      logic [20:0]        elapsed;
      logic               stale;
      logic               stale_began;
   } job_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_TRIG_POSE,
      BK_MUL_VEL,
      BK_SUM_VEL,
      BK_MUL_DT,
      BK_UPDATE,
      BK_START_HALF,
      BK_TRIG_HALF,
      BK_EMIT
   } back_state_type;

endpackage

// ===== design/poi_cordic.sv =====
// ----------------------------------------------------------------------------
// poi_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module poi_cordic
   import poi_pkg::*;
#(
   parameter int TRIG_ITERATIONS = POI_TRIG_ITER_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              angle,
   output logic                     done,
   output logic signed [POI_CW-1:0] cos_out,
   output logic signed [POI_CW-1:0] sin_out
);

   localparam logic [POI_CNT_W-1:0] LastStep = POI_CNT_W'(TRIG_ITERATIONS - 1);

   logic signed [POI_CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [POI_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                     busy_ff, busy_in, done_ff, done_in, flip_ff, flip_in;
   logic                     flip_now;

   assign flip_now = angle[31] ^ angle[30];

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      flip_in = flip_ff;
      done_in = 1'b0;
      if (start) begin
         // fold into the right half-plane, negate at the end
         flip_in = flip_now;
         x_in    = POI_CORDIC_K;
         y_in    = '0;
         z_in    = POI_CW'($signed({angle[31] ^ flip_now, angle[30:0]}));
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[POI_CW-1]) begin
            x_in = x_ff - (y_ff >>> cnt_ff);
            y_in = y_ff + (x_ff >>> cnt_ff);
            z_in = z_ff - POI_ATAN_TAB[cnt_ff];
         end else begin
            x_in = x_ff + (y_ff >>> cnt_ff);
            y_in = y_ff - (x_ff >>> cnt_ff);
            z_in = z_ff + POI_ATAN_TAB[cnt_ff];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      cnt_ff  <= cnt_in;
      flip_ff <= flip_in;
   end

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule

// ===== design/poi_fifo.sv =====
// ----------------------------------------------------------------------------
// poi_fifo
// Two-entry job queue between the command front and the pose back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module poi_fifo
   import poi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output job_type head_job
);

   job_type    mem_ff [POI_FIFO_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'(POI_FIFO_DEPTH));
   assign empty    = (count_ff == 2'd0);
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   `POI_ASSERT_IMPL(fifo_no_overflow, clock, reset, push, !full || pop)
   `POI_ASSERT_IMPL(fifo_no_underflow, clock, reset, pop, !empty)

endmodule

// ===== design/poi_front.sv =====
// ----------------------------------------------------------------------------
// poi_front
// Accepts transactions, keeps the velocity command and its age, and queues
// tick and restart jobs for the back end.
// ----------------------------------------------------------------------------
module poi_front
   import poi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [23:0] req_vel_x,
   input  logic signed [23:0] req_vel_y,
   input  logic signed [31:0] req_turn_rate,
   input  logic [20:0]        req_elapsed,
   input  logic [25:0]        stale_limit,
   input  logic               queue_full,
   output logic               push,
   output job_type            push_job
);

   logic signed [23:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic signed [31:0] turn_ff, turn_in;
   logic [26:0]        age_ff, age_in;
   logic               stale_ff, stale_in;
   logic               accept, stale_now;
   logic [27:0]        age_sum;
   logic [26:0]        age_sat;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign age_sum   = {1'b0, age_ff} + 28'(req_elapsed);
   assign age_sat   = age_sum[27] ? POI_AGE_MAX : age_sum[26:0];
   assign stale_now = (stale_limit != '0) && (age_sat > 27'(stale_limit));

   always_comb begin
      vel_x_in = vel_x_ff;
      vel_y_in = vel_y_ff;
      turn_in  = turn_ff;
      age_in   = age_ff;
      stale_in = stale_ff;
      push     = 1'b0;
      push_job = '{kind: JOB_TICK, vel_x: '0, vel_y: '0, turn_rate: '0,
                   elapsed: req_elapsed, stale: stale_now,
                   stale_began: stale_now && !stale_ff};
      if (accept) begin
         case (cmd_type'(req_cmd))
            CMD_LATCH: begin
               vel_x_in = req_vel_x;
               vel_y_in = req_vel_y;
               turn_in  = req_turn_rate;
               age_in   = '0;
               stale_in = 1'b0;
            end
            CMD_TICK: begin
               age_in = age_sat;
               push   = 1'b1;
               if (stale_now) begin
                  stale_in = 1'b1;
               end else begin
                  push_job.vel_x     = vel_x_ff;
                  push_job.vel_y     = vel_y_ff;
                  push_job.turn_rate = turn_ff;
               end
            end
            CMD_RESTART: begin
               push          = 1'b1;
               push_job.kind = JOB_RESTART;
            end
            default: begin
               // unused selector: drop
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_x_ff <= '0;
         vel_y_ff <= '0;
         turn_ff  <= '0;
         age_ff   <= '0;
         stale_ff <= 1'b0;
      end else begin
         vel_x_ff <= vel_x_in;
         vel_y_ff <= vel_y_in;
         turn_ff  <= turn_in;
         age_ff   <= age_in;
         stale_ff <= stale_in;
      end
   end

endmodule

// ===== design/poi_back.sv =====
// ----------------------------------------------------------------------------
// poi_back
// Pose back end: rotates the twist by the heading, integrates the pose and
// forms the half-angle quaternion with a shared CORDIC unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module poi_back
   import poi_pkg::*;
#(
   parameter int TRIG_ITERATIONS = POI_TRIG_ITER_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_empty,
   input  job_type            head_job,
   output logic               pop,
   input  logic signed [47:0] start_x,
   input  logic signed [47:0] start_y,
   input  logic [31:0]        start_heading,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [47:0] rsp_pos_x,
   output logic signed [47:0] rsp_pos_y,
   output logic [31:0]        rsp_heading,
   output logic signed [15:0] rsp_quat_z,
   output logic signed [15:0] rsp_quat_w,
   output logic signed [23:0] rsp_used_vel_x,
   output logic signed [23:0] rsp_used_vel_y,
   output logic signed [31:0] rsp_used_turn_rate,
   output logic               rsp_stale,
   output logic               rsp_stale_began
);

   back_state_type state_ff, state_in;

   logic                     trig_start, trig_done;
   logic [31:0]              trig_angle;
   logic signed [POI_CW-1:0] trig_cos, trig_sin;

   logic load_job, restart_now, take_trig, do_mul_vel, do_sum, do_mul_dt;
   logic do_update, emit, out_free;
   logic trig_state;

   job_type            job_ff;
   logic signed [47:0] pose_x_ff, pose_x_in, pose_y_ff, pose_y_in;
   logic [31:0]        pose_h_ff, pose_h_in;
   logic signed [POI_CW-1:0] cos_ff, sin_ff;
   logic signed [57:0] p_xc_ff, p_ys_ff, p_xs_ff, p_yc_ff;
   logic signed [40:0] rv_x_ff, rv_y_ff;
   logic signed [53:0] turn_prod_ff;
   logic signed [62:0] dx_prod_ff, dy_prod_ff;
   logic signed [21:0] dt_s;
   logic signed [58:0] sum_x, sum_y;
   logic signed [62:0] dx_rnd, dy_rnd;
   logic [53:0]        turn_rnd;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] qz_in, qw_in;

   function automatic logic signed [15:0] to_q15(input logic signed [POI_CW-1:0] v);
      logic signed [POI_CW:0]   r;
      logic signed [POI_CW-15:0] q;
      r = {v[POI_CW-1], v} + (POI_CW+1)'(1 << 14);
      q = (POI_CW-14)'(r >>> 15);
      if (q > 20'sd32767) begin
         to_q15 = 16'sh7FFF;
      end else if (q < -20'sd32768) begin
         to_q15 = 16'sh8000;
      end else begin
         to_q15 = q[15:0];
      end
   endfunction

   poi_cordic #(
      .TRIG_ITERATIONS(TRIG_ITERATIONS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (trig_start),
      .angle  (trig_angle),
      .done   (trig_done),
      .cos_out(trig_cos),
      .sin_out(trig_sin)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty && head_job.kind == JOB_TICK) begin
               state_in = BK_TRIG_POSE;
            end
         end
         BK_TRIG_POSE:  if (trig_done) state_in = BK_MUL_VEL;
         BK_MUL_VEL:    state_in = BK_SUM_VEL;
         BK_SUM_VEL:    state_in = BK_MUL_DT;
         BK_MUL_DT:     state_in = BK_UPDATE;
         BK_UPDATE:     state_in = BK_START_HALF;
         BK_START_HALF: state_in = BK_TRIG_HALF;
         BK_TRIG_HALF:  if (trig_done) state_in = BK_EMIT;
         BK_EMIT:       if (out_free) state_in = BK_IDLE;
         default:       state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop         = 1'b0;
      load_job    = 1'b0;
      restart_now = 1'b0;
      trig_start  = 1'b0;
      trig_angle  = pose_h_ff;
      take_trig   = 1'b0;
      do_mul_vel  = 1'b0;
      do_sum      = 1'b0;
      do_mul_dt   = 1'b0;
      do_update   = 1'b0;
      emit        = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               if (head_job.kind == JOB_RESTART) begin
                  restart_now = 1'b1;
               end else begin
                  load_job   = 1'b1;
                  trig_start = 1'b1;
               end
            end
         end
         BK_TRIG_POSE:  take_trig = trig_done;
         BK_MUL_VEL:    do_mul_vel = 1'b1;
         BK_SUM_VEL:    do_sum = 1'b1;
         BK_MUL_DT:     do_mul_dt = 1'b1;
         BK_UPDATE:     do_update = 1'b1;
         BK_START_HALF: begin
            trig_start = 1'b1;
            trig_angle = {pose_h_ff[31], pose_h_ff[31:1]};
         end
         BK_EMIT:       emit = out_free;
         default: begin
         end
      endcase
   end

   // datapath
   assign dt_s     = $signed({1'b0, job_ff.elapsed});
   assign sum_x    = p_xc_ff - p_ys_ff + 59'sd8192;
   assign sum_y    = p_xs_ff + p_yc_ff + 59'sd8192;
   assign dx_rnd   = dx_prod_ff + (63'sd1 <<< 35);
   assign dy_rnd   = dy_prod_ff + (63'sd1 <<< 35);
   assign turn_rnd = turn_prod_ff + 54'sd128;
   assign qz_in    = to_q15(trig_sin);
   assign qw_in    = to_q15(trig_cos);

   always_comb begin
      pose_x_in = pose_x_ff;
      pose_y_in = pose_y_ff;
      pose_h_in = pose_h_ff;
      if (restart_now) begin
         pose_x_in = start_x;
         pose_y_in = start_y;
         pose_h_in = start_heading;
      end else if (do_update) begin
         pose_x_in = pose_x_ff + 48'(dx_rnd >>> 36);
         pose_y_in = pose_y_ff + 48'(dy_rnd >>> 36);
         pose_h_in = pose_h_ff + turn_rnd[39:8];
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         pose_h_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pose_x_ff    <= pose_x_in;
         pose_y_ff    <= pose_y_in;
         pose_h_ff    <= pose_h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_job) begin
         job_ff <= head_job;
      end
      if (take_trig) begin
         cos_ff <= trig_cos;
         sin_ff <= trig_sin;
      end
      if (do_mul_vel) begin
         p_xc_ff      <= job_ff.vel_x * cos_ff;
         p_ys_ff      <= job_ff.vel_y * sin_ff;
         p_xs_ff      <= job_ff.vel_x * sin_ff;
         p_yc_ff      <= job_ff.vel_y * cos_ff;
         turn_prod_ff <= job_ff.turn_rate * dt_s;
      end
      if (do_sum) begin
         rv_x_ff <= 41'(sum_x >>> 14);
         rv_y_ff <= 41'(sum_y >>> 14);
      end
      if (do_mul_dt) begin
         dx_prod_ff <= rv_x_ff * dt_s;
         dy_prod_ff <= rv_y_ff * dt_s;
      end
      if (emit) begin
         rsp_pos_x          <= pose_x_ff;
         rsp_pos_y          <= pose_y_ff;
         rsp_heading        <= pose_h_ff;
         rsp_quat_z         <= qz_in;
         rsp_quat_w         <= qw_in;
         rsp_used_vel_x     <= job_ff.vel_x;
         rsp_used_vel_y     <= job_ff.vel_y;
         rsp_used_turn_rate <= job_ff.turn_rate;
         rsp_stale          <= job_ff.stale;
         rsp_stale_began    <= job_ff.stale_began;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign trig_state = (state_ff == BK_TRIG_POSE) || (state_ff == BK_TRIG_HALF);

   `POI_ASSERT_IMPL(back_trig_done_expected, clock, reset, trig_done, trig_state)

endmodule

// ===== design/planar_odometry_integrator_core.sv =====
// A tick job passes the back-end states in order: pose CORDIC run, velocity multiply,
// sum, multiply by elapsed time, pose update, half-angle CORDIC run and emit.
// The back end takes a new job only after the last result is emitted; the shared CORDIC
// unit runs twice per tick. Latch transactions are taken every cycle while the queue has room.
// Reset: synchronous, active high; pose, command, age, stale flag and CSR registers clear to zero.
// ----------------------------------------------------------------------------
// planar_odometry_integrator_core
// Dead-reckoning pose integrator with command timeout and quaternion output.
// ----------------------------------------------------------------------------
module planar_odometry_integrator_core
   import poi_pkg::*;
#(
   parameter int TRIG_ITERATIONS = POI_TRIG_ITER_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wen,
   input  logic [1:0]         csr_index,
   input  logic [47:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [23:0] req_vel_x,
   input  logic signed [23:0] req_vel_y,
   input  logic signed [31:0] req_turn_rate,
   input  logic [20:0]        req_elapsed,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [47:0] rsp_pos_x,
   output logic signed [47:0] rsp_pos_y,
   output logic [31:0]        rsp_heading,
   output logic signed [15:0] rsp_quat_z,
   output logic signed [15:0] rsp_quat_w,
   output logic signed [23:0] rsp_used_vel_x,
   output logic signed [23:0] rsp_used_vel_y,
   output logic signed [31:0] rsp_used_turn_rate,
   output logic               rsp_stale,
   output logic               rsp_stale_began
);

   logic [25:0]        stale_limit_ff;
   logic signed [47:0] start_x_ff, start_y_ff;
   logic [31:0]        start_h_ff;

   logic    push, pop, q_full, q_empty;
   job_type push_job, head_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         stale_limit_ff <= '0;
         start_x_ff     <= '0;
         start_y_ff     <= '0;
         start_h_ff     <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_STALE_LIMIT:   stale_limit_ff <= csr_wdata[25:0];
            CSR_START_X:       start_x_ff     <= csr_wdata;
            CSR_START_Y:       start_y_ff     <= csr_wdata;
            CSR_START_HEADING: start_h_ff     <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   poi_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_vel_x    (req_vel_x),
      .req_vel_y    (req_vel_y),
      .req_turn_rate(req_turn_rate),
      .req_elapsed  (req_elapsed),
      .stale_limit  (stale_limit_ff),
      .queue_full   (q_full),
      .push         (push),
      .push_job     (push_job)
   );

   poi_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(push_job),
      .pop     (pop),
      .full    (q_full),
      .empty   (q_empty),
      .head_job(head_job)
   );

   poi_back #(
      .TRIG_ITERATIONS(TRIG_ITERATIONS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (q_empty),
      .head_job          (head_job),
      .pop               (pop),
      .start_x           (start_x_ff),
      .start_y           (start_y_ff),
      .start_heading     (start_h_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_heading       (rsp_heading),
      .rsp_quat_z        (rsp_quat_z),
      .rsp_quat_w        (rsp_quat_w),
      .rsp_used_vel_x    (rsp_used_vel_x),
      .rsp_used_vel_y    (rsp_used_vel_y),
      .rsp_used_turn_rate(rsp_used_turn_rate),
      .rsp_stale         (rsp_stale),
      .rsp_stale_began   (rsp_stale_began)
   );

endmodule
